### rtl/histeq_pkg.sv
package histeq_pkg;

    localparam int DIM_WIDTH       = 13;
    localparam int PIXEL_WIDTH     = 8;
    localparam int LEVEL_WIDTH     = 8;
    localparam int PROD_WIDTH      = 2 * DIM_WIDTH;
    localparam int LEVEL_MAX       = 255;
    localparam int BINS_DEFAULT    = 256;
    localparam int COUNT_WIDTH_DEF = 25;
    localparam int QUOT_STEPS      = LEVEL_WIDTH;
    localparam int STEP_WIDTH      = $clog2(QUOT_STEPS);
    localparam int REG_INDEX_WIDTH = 1;

    typedef enum logic [REG_INDEX_WIDTH-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } reg_index_t;

    typedef enum logic {
        MODE_HISTOGRAM = 1'b0,
        MODE_MAPPING   = 1'b1
    } mode_t;

    typedef struct packed {
        logic                   mode;
        logic [PIXEL_WIDTH-1:0] pixel;
        logic                   last;
    } item_t;

    typedef struct packed {
        logic [LEVEL_WIDTH-1:0] equalized;
        logic                   end_of_image;
    } result_t;

    typedef struct packed {
        logic load;
        logic hist_rd;
        logic hist_wr;
        logic cdf_init;
        logic cdf_rd;
        logic clr_wr;
        logic map_rd;
        logic map_prep;
        logic map_scale;
        logic map_sat;
        logic div_step;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic mode;
        logic last;
    } status_t;

endpackage

### rtl/histeq_ctrl.sv
module histeq_ctrl #(
    parameter int BINS = histeq_pkg::BINS_DEFAULT
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  histeq_pkg::status_t      status,
    output logic                     busy,
    output histeq_pkg::cmd_t         cmd,
    output logic [$clog2(BINS)-1:0]  sweep_addr
);

    localparam int BIN_AW = $clog2(BINS);

    typedef enum logic [10:0] {
        ST_CLEAR     = 11'b000_0000_0001,
        ST_IDLE      = 11'b000_0000_0010,
        ST_HIST_RD   = 11'b000_0000_0100,
        ST_HIST_WR   = 11'b000_0000_1000,
        ST_CDF_RUN   = 11'b000_0001_0000,
        ST_CDF_DRAIN = 11'b000_0010_0000,
        ST_MAP_RD    = 11'b000_0100_0000,
        ST_MAP_PREP  = 11'b000_1000_0000,
        ST_MAP_SCALE = 11'b001_0000_0000,
        ST_MAP_SAT   = 11'b010_0000_0000,
        ST_MAP_DIV   = 11'b100_0000_0000
    } state_t;

    state_t                               state_reg, state_next;
    logic [BIN_AW-1:0]                    cnt_reg, cnt_next;
    logic [histeq_pkg::STEP_WIDTH-1:0]    step_reg, step_next;
    logic                                 cnt_end;

    assign cnt_end    = (cnt_reg == BIN_AW'(BINS - 1));
    assign sweep_addr = cnt_reg;
    assign busy       = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        step_next  = step_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_end)
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_HIST_RD;
                end
            end
            ST_HIST_RD:
            begin
                if (status.mode == histeq_pkg::MODE_MAPPING)
                begin
                    cmd.map_rd = 1'b1;
                    state_next = ST_MAP_PREP;
                end
                else
                begin
                    cmd.hist_rd = 1'b1;
                    state_next  = ST_HIST_WR;
                end
            end
            ST_HIST_WR:
            begin
                cmd.hist_wr = 1'b1;
                if (status.last)
                begin
                    cmd.cdf_init = 1'b1;
                    state_next   = ST_CDF_RUN;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_CDF_RUN:
            begin
                cmd.cdf_rd = 1'b1;
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_end)
                begin
                    cnt_next   = '0;
                    state_next = ST_CDF_DRAIN;
                end
            end
            ST_CDF_DRAIN:
            begin
                state_next = ST_IDLE;
            end
            ST_MAP_RD:
            begin
                cmd.map_rd = 1'b1;
                state_next = ST_MAP_PREP;
            end
            ST_MAP_PREP:
            begin
                cmd.map_prep = 1'b1;
                state_next   = ST_MAP_SCALE;
            end
            ST_MAP_SCALE:
            begin
                cmd.map_scale = 1'b1;
                state_next    = ST_MAP_SAT;
            end
            ST_MAP_SAT:
            begin
                cmd.map_sat = 1'b1;
                step_next   = histeq_pkg::STEP_WIDTH'(histeq_pkg::QUOT_STEPS - 1);
                state_next  = ST_MAP_DIV;
            end
            ST_MAP_DIV:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    cmd.finish = 1'b1;
                    state_next = status.last ? ST_CLEAR : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            cnt_reg   <= '0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            step_reg  <= step_next;
        end
    end

endmodule

### rtl/histeq_dp.sv
module histeq_dp #(
    parameter int BINS        = histeq_pkg::BINS_DEFAULT,
    parameter int COUNT_WIDTH = histeq_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  histeq_pkg::cmd_t                      cmd,
    input  logic [$clog2(BINS)-1:0]               sweep_addr,
    input  histeq_pkg::item_t                     item,
    input  logic                                  cfg_we,
    input  logic [histeq_pkg::REG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [histeq_pkg::DIM_WIDTH-1:0]      cfg_data,
    output histeq_pkg::status_t                   status,
    output histeq_pkg::result_t                   result,
    output logic                                  result_valid
);

    localparam int BIN_AW = $clog2(BINS);
    localparam int CW     = COUNT_WIDTH;
    localparam int NW     = histeq_pkg::PROD_WIDTH;
    localparam int DW     = (NW > CW) ? NW : CW;
    localparam int XW     = ((CW + 9 > DW) ? CW + 9 : DW) + 1;
    localparam int SW     = DW + 9;
    localparam int RW     = (XW > SW) ? XW : SW;
    localparam int LW     = histeq_pkg::LEVEL_WIDTH;

    logic [CW-1:0] bin_mem [BINS];
    logic [CW-1:0] cdf_mem [BINS];

    logic [histeq_pkg::DIM_WIDTH-1:0] width_reg, height_reg;
    logic [NW-1:0]      n_reg;
    logic               mode_reg, last_reg;
    logic [BIN_AW-1:0]  idx_reg, idx_in;
    logic [CW-1:0]      bin_rd_reg, cdf_rd_reg;
    logic               acc_v_reg;
    logic [BIN_AW-1:0]  acc_addr_reg;
    logic [CW-1:0]      sum_reg, sum_next;
    logic [CW:0]        sum_wide;
    logic [CW-1:0]      cmin_reg;
    logic [CW-1:0]      num_reg;
    logic [DW-1:0]      den_reg;
    logic               zero_reg, sat_reg;
    logic [RW-1:0]      r_reg, dsh_reg;
    logic [LW-1:0]      q_reg;
    logic               done_reg;
    logic [CW-1:0]      bin_inc;
    logic               div_ge;

    assign idx_in = (32'(item.pixel) >= BINS) ? BIN_AW'(BINS - 1) : BIN_AW'(item.pixel);
    assign bin_inc = (&bin_rd_reg) ? bin_rd_reg : bin_rd_reg + 1'b1;
    assign sum_wide = {1'b0, sum_reg} + {1'b0, bin_rd_reg};
    assign sum_next = sum_wide[CW] ? {CW{1'b1}} : sum_wide[CW-1:0];
    assign div_ge   = (r_reg >= dsh_reg);

    assign status.mode = mode_reg;
    assign status.last = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= histeq_pkg::DIM_WIDTH'(1);
            height_reg <= histeq_pkg::DIM_WIDTH'(1);
        end
        else if (cfg_we)
        begin
            unique case (histeq_pkg::reg_index_t'(cfg_index))
                histeq_pkg::REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                histeq_pkg::REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg <= NW'(width_reg) * NW'(height_reg);
    end

    // bin store
    always_ff @(posedge clk)
    begin
        if (cmd.hist_rd)
        begin
            bin_rd_reg <= bin_mem[idx_reg];
        end
        else if (cmd.cdf_rd)
        begin
            bin_rd_reg <= bin_mem[sweep_addr];
        end
        if (cmd.hist_wr)
        begin
            bin_mem[idx_reg] <= bin_inc;
        end
        else if (cmd.clr_wr)
        begin
            bin_mem[sweep_addr] <= '0;
        end
    end

    // cumulative store
    always_ff @(posedge clk)
    begin
        if (acc_v_reg)
        begin
            cdf_mem[acc_addr_reg] <= sum_next;
        end
        if (cmd.map_rd)
        begin
            cdf_rd_reg <= cdf_mem[idx_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= item.mode;
            last_reg <= item.last;
            idx_reg  <= idx_in;
        end
        acc_addr_reg <= sweep_addr;
        if (cmd.cdf_init)
        begin
            sum_reg <= '0;
        end
        else if (acc_v_reg)
        begin
            sum_reg <= sum_next;
        end
        if (cmd.map_prep)
        begin
            num_reg  <= cdf_rd_reg - cmin_reg;
            den_reg  <= DW'(n_reg) - DW'(cmin_reg);
            zero_reg <= (DW'(n_reg) <= DW'(cmin_reg)) || (cdf_rd_reg <= cmin_reg);
        end
        if (cmd.map_scale)
        begin
            r_reg   <= (RW'(num_reg) << 9) - (RW'(num_reg) << 1) + RW'(den_reg);
            dsh_reg <= RW'(den_reg) << 8;
        end
        if (cmd.map_sat)
        begin
            sat_reg <= (r_reg >= (dsh_reg << 1));
        end
        if (cmd.div_step)
        begin
            if (div_ge)
            begin
                r_reg <= r_reg - dsh_reg;
            end
            dsh_reg <= dsh_reg >> 1;
            q_reg   <= {q_reg[LW-2:0], div_ge};
        end
        if (cmd.finish)
        begin
            result.end_of_image <= last_reg;
            if (zero_reg)
            begin
                result.equalized <= '0;
            end
            else if (sat_reg)
            begin
                result.equalized <= LW'(histeq_pkg::LEVEL_MAX);
            end
            else
            begin
                result.equalized <= {q_reg[LW-2:0], div_ge};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_v_reg <= 1'b0;
            done_reg  <= 1'b0;
            cmin_reg  <= '0;
        end
        else
        begin
            acc_v_reg <= cmd.cdf_rd;
            done_reg  <= cmd.finish;
            if (cmd.cdf_init)
            begin
                cmin_reg <= '0;
            end
            else if (acc_v_reg && (cmin_reg == '0))
            begin
                cmin_reg <= sum_next;
            end
        end
    end

    assign result_valid = done_reg;

endmodule

### rtl/histogram_equalizer.sv
// Two-pass 8-bit histogram equalizer. Pulse start while busy is low to hand in one pixel;
// busy then stays high until the block can take the next. A histogram-pass pixel reads
// its bin, then increments and writes it back. The last histogram pixel adds a cumulative
// sweep over the bin memory. A mapping-pass pixel ends in the restoring divider that
// produces one quotient bit per cycle; its result appears on result with result_valid
// high for exactly one cycle and must be taken then. The last mapping pixel starts a
// clearing sweep of the bins, and the same sweep runs after reset, with busy high
// throughout.
module histogram_equalizer #(
    parameter int BINS        = histeq_pkg::BINS_DEFAULT,
    parameter int COUNT_WIDTH = histeq_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  histeq_pkg::item_t                      item,
    output histeq_pkg::result_t                    result,
    output logic                                   result_valid,
    input  logic                                   cfg_we,
    input  logic [histeq_pkg::REG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [histeq_pkg::DIM_WIDTH-1:0]       cfg_data
);

    histeq_pkg::cmd_t          cmd;
    histeq_pkg::status_t       status;
    logic [$clog2(BINS)-1:0]   sweep_addr;

    histeq_ctrl #(
        .BINS(BINS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .status    (status),
        .busy      (busy),
        .cmd       (cmd),
        .sweep_addr(sweep_addr)
    );

    histeq_dp #(
        .BINS       (BINS),
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sweep_addr  (sweep_addr),
        .item        (item),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .status      (status),
        .result      (result),
        .result_valid(result_valid)
    );

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not raise busy");

    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
        else $error("result without work in progress");

    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe longer than one cycle");

    a_one_bin_write: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.hist_wr, cmd.clr_wr, cmd.cdf_rd, cmd.hist_rd}))
        else $error("conflicting bin memory commands");

endmodule

### dv/histogram_equalizer_tb.sv
`timescale 1ns / 100ps

module histogram_equalizer_tb;

    import histeq_pkg::*;

    localparam int NUM_BINS  = 256;
    localparam int CNT_W     = 25;
    localparam int ITEM_GOAL = 950;
    localparam int CALM_TAIL = 150;
    localparam int WD_LIMIT  = 4000;

    class equalizer_scoreboard;
        bit [DIM_WIDTH-1:0]   img_w;
        bit [DIM_WIDTH-1:0]   img_h;
        bit [CNT_W-1:0]       bin_cnt [NUM_BINS];
        bit [CNT_W-1:0]       cum_cnt [NUM_BINS];
        bit [CNT_W-1:0]       cdf_min;
        result_t              levels_due [$];
        int                   errors;

        function new();
            img_w   = 1;
            img_h   = 1;
            cdf_min = 0;
            errors  = 0;
            foreach (bin_cnt[i])
            begin
                bin_cnt[i] = '0;
                cum_cnt[i] = '0;
            end
        endfunction

        function void set_reg(reg_index_t idx, bit [DIM_WIDTH-1:0] val);
            if (idx == REG_IMAGE_WIDTH)
                img_w = val;
            else
                img_h = val;
        endfunction

        function bit [LEVEL_WIDTH-1:0] level_of(bit [CNT_W-1:0] c);
            longint n;
            longint num;
            longint den;
            longint q;
            n = longint'(img_w) * longint'(img_h);
            if (n <= cdf_min || c <= cdf_min)
                return '0;
            num = c - cdf_min;
            den = n - cdf_min;
            q = (2 * LEVEL_MAX * num + den) / (2 * den);
            if (q > LEVEL_MAX)
                q = LEVEL_MAX;
            return q[LEVEL_WIDTH-1:0];
        endfunction

        function void note_item(item_t it);
            longint sum;
            result_t r;
            if (it.mode == MODE_HISTOGRAM)
            begin
                if (bin_cnt[it.pixel] != {CNT_W{1'b1}})
                    bin_cnt[it.pixel]++;
                if (it.last)
                begin
                    sum = 0;
                    cdf_min = 0;
                    for (int i = 0; i < NUM_BINS; i++)
                    begin
                        sum += bin_cnt[i];
                        if (sum > {CNT_W{1'b1}})
                            sum = {CNT_W{1'b1}};
                        cum_cnt[i] = sum[CNT_W-1:0];
                        if (cdf_min == 0)
                            cdf_min = sum[CNT_W-1:0];
                    end
                end
            end
            else
            begin
                r.equalized    = level_of(cum_cnt[it.pixel]);
                r.end_of_image = it.last;
                levels_due.push_back(r);
                if (it.last)
                    foreach (bin_cnt[i])
                        bin_cnt[i] = '0;
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (levels_due.size() == 0)
            begin
                $display("%0t: unexpected result equalized=%0d end_of_image=%0b",
                         $time, got.equalized, got.end_of_image);
                errors++;
                return;
            end
            want = levels_due.pop_front();
            if (got.equalized !== want.equalized)
            begin
                $display("%0t: equalized expected %0d actual %0d",
                         $time, want.equalized, got.equalized);
                errors++;
            end
            if (got.end_of_image !== want.end_of_image)
            begin
                $display("%0t: end_of_image expected %0b actual %0b",
                         $time, want.end_of_image, got.end_of_image);
                errors++;
            end
        endfunction
    endclass

    logic                       clk;
    logic                       rst_n;
    logic                       start;
    logic                       busy;
    item_t                      item;
    result_t                    result;
    logic                       result_valid;
    logic                       cfg_we;
    logic [REG_INDEX_WIDTH-1:0] cfg_index;
    logic [DIM_WIDTH-1:0]       cfg_data;

    equalizer_scoreboard sb;
    int  pixels_taken;
    int  idle_gap_cycles;
    bit  cdf_ready;
    bit  calm;
    int  stall_cycles;

    histogram_equalizer uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result       (result),
        .result_valid (result_valid),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // check before note: a result never belongs to the beat taken at the same edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid)
                sb.check_result(result);
            if (start && !busy)
            begin
                sb.note_item(item);
                pixels_taken++;
            end
            if (result_valid || (start && !busy))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= WD_LIMIT)
            begin
                $display("%0t: watchdog expired", $time);
                $display("** histogram_equalizer: FAILED **");
                $finish;
            end
        end
    end

    task automatic pause();
        int n;
        start <= 1'b0;
        n = $urandom_range(1, 9);
        repeat (n) @(posedge clk);
    endtask

    task automatic send_pixel(bit mode, bit [7:0] pix, bit lst);
        item_t it;
        it.mode  = mode;
        it.pixel = pix;
        it.last  = lst;
        start <= 1'b1;
        item  <= it;
        do
            @(posedge clk);
        while (busy);
        if (mode == MODE_HISTOGRAM && lst)
            cdf_ready = 1'b1;
        if (!calm && $urandom_range(0, 5) == 0)
            pause();
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (sb.levels_due.size() != 0 || busy)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(reg_index_t idx, bit [DIM_WIDTH-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        sb.set_reg(idx, val);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_size(bit [DIM_WIDTH-1:0] w, bit [DIM_WIDTH-1:0] h);
        drain();
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
    endtask

    function automatic bit [7:0] pick_level(int style, bit [7:0] base);
        case (style)
            0: return 8'($urandom_range(0, 255));
            1: return base + 8'($urandom_range(0, 7));
            2: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            default: return 8'($urandom_range(0, 3)) << 6 | 8'($urandom_range(0, 1));
        endcase
    endfunction

    task automatic run_image(int n_hist, int n_map);
        int style;
        bit [7:0] base;
        style = $urandom_range(0, 3);
        base  = 8'($urandom_range(0, 248));
        for (int i = 0; i < n_hist; i++)
            send_pixel(MODE_HISTOGRAM, pick_level(style, base), i == n_hist - 1);
        for (int i = 0; i < n_map; i++)
            send_pixel(MODE_MAPPING, pick_level(style, base), i == n_map - 1);
    endtask

    initial
    begin
        int w;
        int h;
        int n;
        int roll;
        sb = new();
        pixels_taken = 0;
        stall_cycles = 0;
        cdf_ready = 1'b0;
        calm = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        cfg_we = 1'b0;
        cfg_index = REG_IMAGE_WIDTH;
        cfg_data = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extremes of the levels, image 4x2
        set_size(13'd4, 13'd2);
        send_pixel(MODE_HISTOGRAM, 8'h00, 1'b0);
        send_pixel(MODE_HISTOGRAM, 8'hFF, 1'b0);
        send_pixel(MODE_HISTOGRAM, 8'h00, 1'b0);
        send_pixel(MODE_HISTOGRAM, 8'h80, 1'b0);
        send_pixel(MODE_HISTOGRAM, 8'h55, 1'b0);
        send_pixel(MODE_HISTOGRAM, 8'hAA, 1'b0);
        send_pixel(MODE_HISTOGRAM, 8'h01, 1'b0);
        send_pixel(MODE_HISTOGRAM, 8'hFE, 1'b1);
        send_pixel(MODE_MAPPING, 8'h00, 1'b0);
        send_pixel(MODE_MAPPING, 8'hFF, 1'b0);
        send_pixel(MODE_MAPPING, 8'h80, 1'b0);
        send_pixel(MODE_MAPPING, 8'h07, 1'b1);
        // count beyond size: quotient saturates
        set_size(13'd2, 13'd1);
        send_pixel(MODE_HISTOGRAM, 8'h00, 1'b0);
        send_pixel(MODE_HISTOGRAM, 8'hC8, 1'b0);
        send_pixel(MODE_HISTOGRAM, 8'hC8, 1'b0);
        send_pixel(MODE_HISTOGRAM, 8'hC8, 1'b1);
        send_pixel(MODE_MAPPING, 8'hC8, 1'b0);
        send_pixel(MODE_MAPPING, 8'h00, 1'b1);
        // size at or below the minimum count
        set_size(13'd1, 13'd1);
        send_pixel(MODE_HISTOGRAM, 8'h33, 1'b0);
        send_pixel(MODE_HISTOGRAM, 8'h33, 1'b1);
        send_pixel(MODE_MAPPING, 8'h33, 1'b1);
        set_size(13'd0, 13'd5);
        run_image(2, 2);
        // largest registers
        set_size(13'h1FFF, 13'h1FFF);
        run_image(3, 3);

        while (pixels_taken < ITEM_GOAL)
        begin
            calm = (pixels_taken >= ITEM_GOAL - CALM_TAIL);
            roll = $urandom_range(0, 19);
            if (roll == 0)
            begin
                set_size(13'd4096, 13'd4096);
                run_image($urandom_range(1, 6), $urandom_range(1, 6));
            end
            else if (roll == 1)
            begin
                set_size(13'($urandom_range(0, 8191)), 13'($urandom_range(0, 8191)));
                run_image($urandom_range(1, 6), $urandom_range(1, 6));
            end
            else if (roll <= 3)
            begin
                // noise: free mix of modes and marks
                n = $urandom_range(4, 16);
                for (int i = 0; i < n; i++)
                    send_pixel(cdf_ready ? 1'($urandom_range(0, 1)) : MODE_HISTOGRAM,
                               8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
            end
            else if (roll == 4)
            begin
                w = $urandom_range(1, 6);
                h = $urandom_range(1, 6);
                set_size(13'(w), 13'(h));
                run_image(w * h + $urandom_range(0, 4) - 2 > 0 ? w * h : 1, w * h);
            end
            else
            begin
                w = $urandom_range(1, 8);
                h = $urandom_range(1, 6);
                if ($urandom_range(0, 2) == 0)
                    set_size(13'(w), 13'(h));
                else
                    drain();
                n = int'(sb.img_w) * int'(sb.img_h);
                if (n < 1 || n > 48)
                    set_size(13'(w), 13'(h));
                n = sb.img_w * sb.img_h;
                run_image(n, n);
            end
        end

        start <= 1'b0;
        fork
            begin
                while (sb.levels_due.size() != 0)
                    @(posedge clk);
                repeat (40) @(posedge clk);
            end
            begin
                repeat (WD_LIMIT) @(posedge clk);
                $display("%0t: results still pending at end", $time);
                sb.errors++;
            end
        join_any
        disable fork;

        if (sb.errors == 0 && sb.levels_due.size() == 0)
            $display("** histogram_equalizer: PASSED **");
        else
            $display("** histogram_equalizer: FAILED **");
        $finish;
    end

endmodule

### histogram_equalizer.f
rtl/histeq_pkg.sv
rtl/histeq_ctrl.sv
rtl/histeq_dp.sv
rtl/histogram_equalizer.sv
dv/histogram_equalizer_tb.sv
